// ----- sv/hae_pkg.sv -----
// Shared types and constants for the Halvorsen attractor Euler step block.
// Holds multiplier widths, reset values, register indexes and sequencer codes.
// No dependencies; imported by hae_mul and the top level.
package hae_pkg;

	// Shared multiplier operand and product widths.
	localparam int MUL_W  = 33;
	localparam int PROD_W = 2 * MUL_W;

	// Start point and view offset.
	localparam logic signed [31:0] START_X     = 32'sd1677722;
	localparam int                 VIEW_OFFSET = 139264;

	// Register reset values.
	localparam logic [30:0]        COEF_A_RST     = 31'd23488102;
	localparam logic [24:0]        STEP_SIZE_RST  = 25'd83886;
	localparam logic [30:0]        VIEW_SCALE_RST = 31'd335544320;
	localparam logic signed [31:0] ROT1_COS_RST   = 32'sd868675389;
	localparam logic signed [31:0] ROT1_SIN_RST   = 32'sd631129338;
	localparam logic signed [31:0] ROT2_COS_RST   = 32'sd759250125;
	localparam logic signed [31:0] ROT2_SIN_RST   = 32'sd759250125;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		CFG_COEF_A     = 3'd0,
		CFG_STEP_SIZE  = 3'd1,
		CFG_VIEW_SCALE = 3'd2,
		CFG_ROT1_COS   = 3'd3,
		CFG_ROT1_SIN   = 3'd4,
		CFG_ROT2_COS   = 3'd5,
		CFG_ROT2_SIN   = 3'd6
	} cfg_idx_t;

	// Sequencer control states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FINISH
	} seq_state_t;

	// Multiply operations in issue order.
	typedef enum logic [4:0] {
		OP_AX, OP_YY, OP_AY, OP_ZZ, OP_AZ, OP_XX,
		OP_DXH, OP_DXL, OP_DYH, OP_DYL, OP_DZH, OP_DZL,
		OP_XC1, OP_YS1, OP_YC2, OP_ZS2, OP_YS2, OP_ZC2,
		OP_VX, OP_VY, OP_VZ
	} op_t;

	// Saturated value with overflow mark.
	typedef struct packed {
		logic               ovf;
		logic signed [31:0] val;
	} sat_t;

endpackage

// ----- sv/hae_mul.sv -----
// Shared signed multiplier with a registered product.
// Depends on hae_pkg for the operand and product widths.
module hae_mul import hae_pkg::*; (
	input  logic                     clk,
	input  logic signed [MUL_W-1:0]  op_a,
	input  logic signed [MUL_W-1:0]  op_b,
	output logic signed [PROD_W-1:0] prod_s1
);

	// One full product per cycle, registered for the writeback stage.
	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
	end

endmodule

// ----- sv/halvorsen_attractor_euler_step_top.sv -----
// Halvorsen attractor Euler step: one shared 33x33 multiplier under a sequencer.
// Each input transfer runs 21 products (9 for a restart) one at a time through the
// shared multiplier, then drains the last product and loads the output register, waiting
// while that register is occupied; no new input is taken until the result is loaded.
// Reset (arst_n low, asynchronous) loads the default registers and the start point.
// Depends on hae_pkg and hae_mul.
module halvorsen_attractor_euler_step_top import hae_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// Input channel.
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               restart,
	// Result channel.
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] pos_z,
	output logic signed [31:0] view_x,
	output logic signed [31:0] view_y,
	output logic signed [31:0] view_z,
	output logic               overflow,
	// Configuration write channel.
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam int DW = 42;  // derivative accumulator width
	localparam int TW = 68;  // step product accumulator width
	localparam logic signed [PROD_W-1:0] RND24    = PROD_W'(1) <<< 23;
	localparam logic signed [PROD_W-1:0] RND34    = PROD_W'(1) <<< 33;
	localparam logic signed [PROD_W-1:0] VIEW_RND = PROD_W'(1) <<< 27;
	localparam logic signed [PROD_W-1:0] VX_BIAS  =
		(PROD_W'(VIEW_OFFSET) <<< 28) + VIEW_RND;
	localparam logic signed [TW-1:0]     TACC_RND = TW'(1) <<< 23;
	localparam logic signed [43:0]       SAT_HI   = 44'sd2147483647;
	localparam logic signed [43:0]       SAT_LO   = -44'sd2147483648;

	// Clamp a wide value to the signed 32-bit range.
	function automatic sat_t sat32(input logic signed [43:0] v);
		sat_t r;
		if (v > SAT_HI) begin
			r.ovf = 1'b1;
			r.val = 32'sh7FFFFFFF;
		end else if (v < SAT_LO) begin
			r.ovf = 1'b1;
			r.val = 32'sh80000000;
		end else begin
			r.ovf = 1'b0;
			r.val = v[31:0];
		end
		return r;
	endfunction

	// Configuration registers.
	logic [30:0]        coef_a_q, view_scale_q;
	logic [24:0]        step_size_q;
	logic signed [31:0] rot1_cos_q, rot1_sin_q, rot2_cos_q, rot2_sin_q;

	// Attractor state and sequencer.
	logic signed [31:0] state_x_q, state_y_q, state_z_q;
	logic               flag_q;
	seq_state_t         state_q, state_d;
	op_t                op_q, wb_op_s1;
	logic               wb_valid_s1;
	logic               issue, out_load, out_valid_q;

	// Working registers.
	logic signed [DW-1:0] dx_q, dy_q, dz_q;
	logic signed [TW-1:0] tacc_q;
	logic signed [32:0]   m0_q, m1_q, m2_q;
	logic signed [31:0]   vx_q, vy_q, vz_q;

	// Multiplier connections.
	logic signed [MUL_W-1:0]  op_a, op_b;
	logic signed [PROD_W-1:0] prod_s1;

	// Writeback arithmetic.
	logic signed [PROD_W-1:0] p24, p34, vsum;
	logic signed [DW-1:0]     r24;
	logic signed [31:0]       r34;
	logic signed [TW-1:0]     tsum;
	sat_t                     tsat, vsat;

	assign cfg_ready = 1'b1;

	// Configuration write transfers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q     <= COEF_A_RST;
			step_size_q  <= STEP_SIZE_RST;
			view_scale_q <= VIEW_SCALE_RST;
			rot1_cos_q   <= ROT1_COS_RST;
			rot1_sin_q   <= ROT1_SIN_RST;
			rot2_cos_q   <= ROT2_COS_RST;
			rot2_sin_q   <= ROT2_SIN_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_COEF_A:     coef_a_q     <= cfg_data[30:0];
				CFG_STEP_SIZE:  step_size_q  <= cfg_data[24:0];
				CFG_VIEW_SCALE: view_scale_q <= cfg_data[30:0];
				CFG_ROT1_COS:   rot1_cos_q   <= cfg_data;
				CFG_ROT1_SIN:   rot1_sin_q   <= cfg_data;
				CFG_ROT2_COS:   rot2_cos_q   <= cfg_data;
				CFG_ROT2_SIN:   rot2_sin_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake controls.
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		issue    = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = ST_RUN;
			end
			ST_RUN: begin
				issue = 1'b1;
				if (op_q == OP_VZ) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Operand selection for the operation being issued.
	always_comb begin
		op_a = '0;
		op_b = '0;
		case (op_q)
			OP_AX:  begin op_a = MUL_W'(coef_a_q); op_b = MUL_W'(state_x_q); end
			OP_YY:  begin op_a = MUL_W'(state_y_q); op_b = MUL_W'(state_y_q); end
			OP_AY:  begin op_a = MUL_W'(coef_a_q); op_b = MUL_W'(state_y_q); end
			OP_ZZ:  begin op_a = MUL_W'(state_z_q); op_b = MUL_W'(state_z_q); end
			OP_AZ:  begin op_a = MUL_W'(coef_a_q); op_b = MUL_W'(state_z_q); end
			OP_XX:  begin op_a = MUL_W'(state_x_q); op_b = MUL_W'(state_x_q); end
			OP_DXH: begin op_a = MUL_W'($signed(dx_q[DW-1:16])); op_b = MUL_W'(step_size_q); end
			OP_DXL: begin op_a = MUL_W'(dx_q[15:0]); op_b = MUL_W'(step_size_q); end
			OP_DYH: begin op_a = MUL_W'($signed(dy_q[DW-1:16])); op_b = MUL_W'(step_size_q); end
			OP_DYL: begin op_a = MUL_W'(dy_q[15:0]); op_b = MUL_W'(step_size_q); end
			OP_DZH: begin op_a = MUL_W'($signed(dz_q[DW-1:16])); op_b = MUL_W'(step_size_q); end
			OP_DZL: begin op_a = MUL_W'(dz_q[15:0]); op_b = MUL_W'(step_size_q); end
			OP_XC1: begin op_a = MUL_W'(state_x_q); op_b = MUL_W'(rot1_cos_q); end
			OP_YS1: begin op_a = MUL_W'(state_y_q); op_b = MUL_W'(rot1_sin_q); end
			OP_YC2: begin op_a = MUL_W'(state_y_q); op_b = MUL_W'(rot2_cos_q); end
			OP_ZS2: begin op_a = MUL_W'(state_z_q); op_b = MUL_W'(rot2_sin_q); end
			OP_YS2: begin op_a = MUL_W'(state_y_q); op_b = MUL_W'(rot2_sin_q); end
			OP_ZC2: begin op_a = MUL_W'(state_z_q); op_b = MUL_W'(rot2_cos_q); end
			OP_VX:  begin op_a = MUL_W'(view_scale_q); op_b = m0_q; end
			OP_VY:  begin op_a = MUL_W'(view_scale_q); op_b = m1_q; end
			OP_VZ:  begin op_a = MUL_W'(view_scale_q); op_b = m2_q; end
			default: ;
		endcase
	end

	hae_mul u_mul (
		.clk     (clk),
		.op_a    (op_a),
		.op_b    (op_b),
		.prod_s1 (prod_s1)
	);

	// Rounding, step accumulation and clamping of the registered product.
	always_comb begin
		p24  = prod_s1 + RND24;
		r24  = $signed(p24[PROD_W-1:24]);
		p34  = prod_s1 + RND34;
		r34  = $signed(p34[PROD_W-1:34]);
		tsum = tacc_q + TW'(prod_s1);
		tsat = sat32($signed(tsum[TW-1:24]));
		vsum = prod_s1 + ((wb_op_s1 == OP_VX) ? VX_BIAS : VIEW_RND);
		vsat = sat32(44'($signed(vsum[PROD_W-1:28])));
	end

	// Sequencer counter, state update and overflow flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q        <= OP_AX;
			wb_op_s1    <= OP_AX;
			wb_valid_s1 <= 1'b0;
			flag_q      <= 1'b0;
			state_x_q   <= START_X;
			state_y_q   <= '0;
			state_z_q   <= '0;
		end else begin
			wb_valid_s1 <= issue;
			wb_op_s1    <= op_q;
			if (in_valid && in_ready) begin
				flag_q <= 1'b0;
				if (restart) begin
					op_q      <= OP_XC1;
					state_x_q <= START_X;
					state_y_q <= '0;
					state_z_q <= '0;
				end else begin
					op_q <= OP_AX;
				end
			end else if (issue && op_q != OP_VZ) begin
				op_q <= op_t'(op_q + 5'd1);
			end
			if (wb_valid_s1) begin
				case (wb_op_s1)
					OP_DXL: begin state_x_q <= tsat.val; flag_q <= flag_q | tsat.ovf; end
					OP_DYL: begin state_y_q <= tsat.val; flag_q <= flag_q | tsat.ovf; end
					OP_DZL: begin state_z_q <= tsat.val; flag_q <= flag_q | tsat.ovf; end
					OP_VX, OP_VY, OP_VZ: flag_q <= flag_q | vsat.ovf;
					default: ;
				endcase
			end
		end
	end

	// Working registers written back from the multiplier.
	always_ff @(posedge clk) begin
		if (wb_valid_s1) begin
			case (wb_op_s1)
				OP_AX:  dx_q <= -r24 - (DW'(state_y_q) <<< 2) - (DW'(state_z_q) <<< 2);
				OP_YY:  dx_q <= dx_q - r24;
				OP_AY:  dy_q <= -r24 - (DW'(state_z_q) <<< 2) - (DW'(state_x_q) <<< 2);
				OP_ZZ:  dy_q <= dy_q - r24;
				OP_AZ:  dz_q <= -r24 - (DW'(state_x_q) <<< 2) - (DW'(state_y_q) <<< 2);
				OP_XX:  dz_q <= dz_q - r24;
				OP_DXH: tacc_q <= (TW'(prod_s1) <<< 16) + (TW'(state_x_q) <<< 24) + TACC_RND;
				OP_DYH: tacc_q <= (TW'(prod_s1) <<< 16) + (TW'(state_y_q) <<< 24) + TACC_RND;
				OP_DZH: tacc_q <= (TW'(prod_s1) <<< 16) + (TW'(state_z_q) <<< 24) + TACC_RND;
				OP_XC1: m0_q <= 33'(r34);
				OP_YS1: m0_q <= m0_q - 33'(r34);
				OP_YC2: m1_q <= 33'(r34);
				OP_ZS2: m1_q <= m1_q - 33'(r34);
				OP_YS2: m2_q <= 33'(r34);
				OP_ZC2: m2_q <= m2_q + 33'(r34);
				OP_VX:  vx_q <= vsat.val;
				OP_VY:  vy_q <= vsat.val;
				OP_VZ:  vz_q <= vsat.val;
				default: ;
			endcase
		end
	end

	// Output register: holds a finished result until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pos_x    <= state_x_q;
			pos_y    <= state_y_q;
			pos_z    <= state_z_q;
			view_x   <= vx_q;
			view_y   <= vy_q;
			view_z   <= vz_q;
			overflow <= flag_q;
		end
	end

	assign out_valid = out_valid_q;

	// A restart transfer loads the start point at once.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && restart) |=>
			(state_x_q == START_X && state_y_q == 32'sd0 && state_z_q == 32'sd0))
		else $error("restart did not load the start point");

	// The writeback stage handles exactly the operation issued in the cycle before.
	assert property (@(posedge clk) disable iff (!arst_n)
		wb_valid_s1 |-> (wb_op_s1 == $past(op_q) && $past(issue)))
		else $error("writeback does not match the issued operation");

	// Drain follows the last view product.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> (wb_valid_s1 && wb_op_s1 == OP_VZ))
		else $error("drain entered before the last product");

	// A finished result waits while the output register is still occupied.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && out_valid_q && !out_ready) |=> (state_q == ST_FINISH))
		else $error("result loaded over an untaken output");

endmodule
